@@ hdl/tqc_pkg.sv @@
package tqc_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 48;
    localparam int KEY_W       = 64;
    localparam int DUR_W       = 32;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W       = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = ((KEY_W + TIME_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = KEY_W;

    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1000);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_TAKE   = 2'd2,
        FUNC_CHECK  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE        = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_EMPTY       = 3'd2,
        ST_NOT_EXPIRED = 3'd3,
        ST_EXPIRED     = 3'd4,
        ST_FULL        = 3'd5
    } t_status;

    typedef struct packed {
        logic                 valid;
        logic [KEY_W-1:0]     key;
        logic [TIME_BITS-1:0] stamp;
    } t_slot;

    typedef struct packed {
        logic                 match_en;
        logic                 append;
        logic [IDX_W-1:0]     tail;
        logic [KEY_W-1:0]     key;
        logic [TIME_BITS-1:0] stamp;
    } t_cell_ctl;

endpackage

@@ hdl/tqc_cell.sv @@
module tqc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [tqc_pkg::IDX_W-1:0] i_index,
    input  tqc_pkg::t_cell_ctl i_ctl,
    input  logic               i_shift,
    output logic               o_shift,
    input  tqc_pkg::t_slot     i_next,
    output tqc_pkg::t_slot     o_slot
);

    logic                          r_valid;
    logic [tqc_pkg::KEY_W-1:0]     r_key;
    logic [tqc_pkg::TIME_BITS-1:0] r_stamp;
    logic                          n_valid;
    logic [tqc_pkg::KEY_W-1:0]     n_key;
    logic [tqc_pkg::TIME_BITS-1:0] n_stamp;
    logic                          match;

    assign match   = r_valid && i_ctl.match_en && (r_key == i_ctl.key);
    assign o_shift = i_shift | match;

    always_comb begin
        if (i_ctl.append && (i_index == i_ctl.tail)) begin
            n_valid = 1'b1;
            n_key   = i_ctl.key;
            n_stamp = i_ctl.stamp;
        end else if (o_shift) begin
            n_valid = i_next.valid;
            n_key   = i_next.key;
            n_stamp = i_next.stamp;
        end else begin
            n_valid = r_valid;
            n_key   = r_key;
            n_stamp = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_stamp <= n_stamp;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.key   = r_key;
    assign o_slot.stamp = r_stamp;

endmodule

@@ hdl/timeout_queue_with_cancel_top.sv @@
// Arrival-ordered timeout queue of up to 64 keys with delete by key. One
// operation (add, delete, take, check) is taken per clock cycle, and its
// result appears in the output register on the next cycle; a new operation
// is taken whenever the output register is empty or being drained. The
// figure is set by the row of cells: every cell compares its key with the
// incoming key in the same cycle and the row closes any gap by shifting one
// place toward the head. The head's age is (now_time - stamp) mod 2^48,
// compared against expiry_duration (reset value 1000). No clearing pass is
// needed after reset. Write expiry_duration only while no operation is in
// flight.
module timeout_queue_with_cancel_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // order_key [63:0], now_time [111:64]
    input  logic [tqc_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // func [1:0]
    input  logic [tqc_pkg::FUNC_W-1:0]        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // taken_key [63:0]
    output logic [tqc_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // status [2:0]
    output logic [tqc_pkg::STATUS_W-1:0]      o_m_axis_tuser,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tqc_pkg::DUR_W-1:0]         i_cfg_data
);

    localparam int DEPTH = tqc_pkg::QUEUE_DEPTH;

    logic [tqc_pkg::DUR_W-1:0]      r_duration;
    logic [tqc_pkg::CNT_W-1:0]      r_count;
    logic [tqc_pkg::CNT_W-1:0]      n_count;
    logic                           r_out_valid;
    logic                           n_out_valid;
    tqc_pkg::t_status               r_status;
    tqc_pkg::t_status               n_status;
    logic [tqc_pkg::KEY_W-1:0]      r_taken;
    logic [tqc_pkg::KEY_W-1:0]      n_taken;

    logic                           accept;
    tqc_pkg::t_func                 func;
    logic [tqc_pkg::KEY_W-1:0]      in_key;
    logic [tqc_pkg::TIME_BITS-1:0]  in_now;
    logic [tqc_pkg::TIME_BITS-1:0]  age;
    logic                           expired;
    logic                           empty;
    logic                           full;
    logic                           found;
    logic                           pop;
    logic                           append;
    logic [tqc_pkg::CNT_W-1:0]      tail;
    tqc_pkg::t_cell_ctl             ctl;
    logic [DEPTH:0]                 shift_chain;
    tqc_pkg::t_slot                 slots [0:DEPTH];

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign func   = tqc_pkg::t_func'(i_s_axis_tuser);
    assign in_key = i_s_axis_tdata[tqc_pkg::KEY_W-1:0];
    assign in_now = i_s_axis_tdata[tqc_pkg::KEY_W +: tqc_pkg::TIME_BITS];

    assign empty   = (r_count == '0);
    assign full    = (r_count == tqc_pkg::CNT_W'(DEPTH));
    assign age     = in_now - slots[0].stamp;
    assign expired = tqc_pkg::CMP_W'(age) >= tqc_pkg::CMP_W'(r_duration);

    assign pop   = accept && (func == tqc_pkg::FUNC_TAKE) && !empty && expired;
    assign found = shift_chain[DEPTH] && !pop;
    assign tail  = r_count - tqc_pkg::CNT_W'(found);
    assign append = accept && (func == tqc_pkg::FUNC_ADD) && !(full && !found);

    assign ctl.match_en = accept && ((func == tqc_pkg::FUNC_ADD) ||
                                     (func == tqc_pkg::FUNC_DELETE));
    assign ctl.append   = append;
    assign ctl.tail     = tail[tqc_pkg::IDX_W-1:0];
    assign ctl.key      = in_key;
    assign ctl.stamp    = in_now;

    assign shift_chain[0] = pop;
    assign slots[DEPTH]   = '0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        tqc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (tqc_pkg::IDX_W'(gi)),
            .i_ctl   (ctl),
            .i_shift (shift_chain[gi]),
            .o_shift (shift_chain[gi+1]),
            .i_next  (slots[gi+1]),
            .o_slot  (slots[gi])
        );
    end

    always_comb begin
        n_count = r_count - tqc_pkg::CNT_W'(found) - tqc_pkg::CNT_W'(pop)
                + tqc_pkg::CNT_W'(append);
        n_status    = r_status;
        n_taken     = r_taken;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        if (accept) begin
            n_out_valid = 1'b1;
            n_taken     = '0;
            unique case (func)
                tqc_pkg::FUNC_ADD: begin
                    n_status = (full && !found) ? tqc_pkg::ST_FULL : tqc_pkg::ST_DONE;
                end
                tqc_pkg::FUNC_DELETE: begin
                    n_status = found ? tqc_pkg::ST_DONE : tqc_pkg::ST_NOT_FOUND;
                end
                default: begin
                    if (empty) begin
                        n_status = tqc_pkg::ST_EMPTY;
                    end else if (!expired) begin
                        n_status = tqc_pkg::ST_NOT_EXPIRED;
                    end else begin
                        n_status = tqc_pkg::ST_EXPIRED;
                        if (func == tqc_pkg::FUNC_TAKE) begin
                            n_taken = slots[0].key;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration  <= tqc_pkg::DUR_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_duration <= i_cfg_data;
            end
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_taken  <= n_taken;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_taken;
    assign o_m_axis_tuser  = r_status;

endmodule
